// ----- src/twt_pkg.sv -----
// ----------------------------------------------------------------------------
// twt_pkg: shared types and constants for the twiddled texel address unit
// Payload structs, configuration view, register indexes and format codes.
// ----------------------------------------------------------------------------
`default_nettype none

package twt_pkg;

	localparam int MAX_SIDE_LOG2 = 10;

	localparam int COORD_W   = 10;
	localparam int VALUE_W   = 16;
	localparam int BASE_W    = 23;
	localparam int LOG2_W    = 4;
	localparam int FMT_W     = 2;
	localparam int ADDR_W    = 24;
	localparam int SIZE_W    = 2;
	localparam int INDEX_W   = 2 * COORD_W;      // texel index within the level
	localparam int OFFSET_W  = INDEX_W + 1;      // byte offset, 16bpp worst case
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = BASE_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd3;

	// pixel format codes
	localparam logic [FMT_W-1:0] FMT_16BPP  = 2'd0;
	localparam logic [FMT_W-1:0] FMT_8BPP   = 2'd1;
	localparam logic [FMT_W-1:0] FMT_4BPP   = 2'd2;
	localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;   // behaves as 16bpp

	// access size codes
	localparam logic [SIZE_W-1:0] SIZE_HALF   = 2'd0;
	localparam logic [SIZE_W-1:0] SIZE_BYTE   = 2'd1;
	localparam logic [SIZE_W-1:0] SIZE_NIBBLE = 2'd2;

	// reset values
	localparam logic [BASE_W-1:0] BASE_RESET   = '0;
	localparam logic [LOG2_W-1:0] LOG2_RESET   = 4'd3;
	localparam logic [FMT_W-1:0]  FORMAT_RESET = FMT_16BPP;

	typedef struct packed {
		logic [COORD_W-1:0] texel_x;
		logic [COORD_W-1:0] texel_y;
		logic [VALUE_W-1:0] texel_value;
	} texel_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  byte_address;
		logic [VALUE_W-1:0] write_data;
		logic [SIZE_W-1:0]  access_size;
		logic               high_nibble;
		logic               in_range;
	} result_t;

	// level setup as seen by the address logic (sides already clamped)
	typedef struct packed {
		logic [BASE_W-1:0] base_address;
		logic [LOG2_W-1:0] width_log2;
		logic [LOG2_W-1:0] height_log2;
		logic [FMT_W-1:0]  pixel_format;
	} level_cfg_t;

endpackage

`default_nettype wire

// ----- src/twiddled_texel_address.sv -----
// ----------------------------------------------------------------------------
// twiddled_texel_address: VRAM write address for texels of a twiddled level
// Maps (x, y, value) to byte address, data and lane in Morton tile order.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                   payload
//  texel     in   texel_valid / texel_stall   texel_t  (x, y, value)
//  result    out  result_valid / result_stall result_t (address, data, lane)
//  config    in   cfg_write                   cfg_index, cfg_data
//
//  One texel per cycle sustained while result_stall is low. A texel transfer
//  loads the input register; the address logic works from it and the result
//  register captures the result when the result stage can take a new entry.
//  Reset clears both stage valids and loads the register defaults
//  (base 0, 8x8 texels, 16bpp).
//  A stall on the result side holds the result register; the input register
//  still takes a texel while empty, and texel_stall rises once both hold one.
//
`default_nettype none

module twiddled_texel_address
	import twt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	input  wire logic                 texel_valid,
	output logic                      texel_stall,
	input  texel_t                    texel,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_t                   result
);

	level_cfg_t level_cfg;
	texel_t     texel_s1;
	logic       valid_s1;
	result_t    calc_result;
	result_t    result_s2;
	logic       valid_s2;
	logic       load_s2;

	twt_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.level_cfg (level_cfg)
	);

	twt_addr_calc u_addr_calc (
		.level_cfg (level_cfg),
		.texel     (texel_s1),
		.result    (calc_result)
	);

	// result stage takes a new entry when empty or being drained
	assign load_s2     = !valid_s2 || !result_stall;
	// input stage blocks only when it holds a texel that cannot move on
	assign texel_stall = valid_s1 && !load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!texel_stall) begin
				valid_s1 <= texel_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (!texel_stall && texel_valid) begin
			texel_s1 <= texel;
		end
		if (load_s2 && valid_s1) begin
			result_s2 <= calc_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

`default_nettype wire

// ----- src/twt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// twt_cfg_regs: level configuration registers
// Holds base, side sizes and format; presents sides clamped to the maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module twt_cfg_regs
	import twt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	output level_cfg_t                level_cfg
);

	localparam logic [LOG2_W-1:0] MAX_LOG2 = LOG2_W'(MAX_SIDE_LOG2);

	logic [BASE_W-1:0] base_q;
	logic [LOG2_W-1:0] width_log2_q;
	logic [LOG2_W-1:0] height_log2_q;
	logic [FMT_W-1:0]  format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q        <= BASE_RESET;
			width_log2_q  <= LOG2_RESET;
			height_log2_q <= LOG2_RESET;
			format_q      <= FORMAT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BASE_ADDRESS: base_q        <= cfg_data[BASE_W-1:0];
				REG_WIDTH_LOG2:   width_log2_q  <= cfg_data[LOG2_W-1:0];
				REG_HEIGHT_LOG2:  height_log2_q <= cfg_data[LOG2_W-1:0];
				REG_PIXEL_FORMAT: format_q      <= cfg_data[FMT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		level_cfg.base_address = base_q;
		level_cfg.width_log2   = (width_log2_q > MAX_LOG2) ? MAX_LOG2 : width_log2_q;
		level_cfg.height_log2  = (height_log2_q > MAX_LOG2) ? MAX_LOG2 : height_log2_q;
		level_cfg.pixel_format = format_q;
	end

endmodule

`default_nettype wire

// ----- src/twt_addr_calc.sv -----
// ----------------------------------------------------------------------------
// twt_addr_calc: twiddled address and lane for one texel
// Range check, Morton interleave inside the tile, tile stacking, packing.
// ----------------------------------------------------------------------------
`default_nettype none

module twt_addr_calc
	import twt_pkg::*;
(
	input  level_cfg_t level_cfg,
	input  texel_t     texel,
	output result_t    result
);

	localparam int TILE_W  = COORD_W + 1;
	localparam int SHIFT_W = LOG2_W + 1;

	logic [LOG2_W-1:0]   side_log2;
	logic [COORD_W-1:0]  tile_mask;
	logic [COORD_W-1:0]  x_in_tile;
	logic [COORD_W-1:0]  y_in_tile;
	logic [INDEX_W-1:0]  interleaved;
	logic [TILE_W-1:0]   tile_num;
	logic [SHIFT_W-1:0]  tile_shift;
	logic [INDEX_W-1:0]  tile_base;
	logic [INDEX_W-1:0]  texel_index;
	logic [OFFSET_W-1:0] offset;
	logic                outside;

	always_comb begin
		side_log2 = (level_cfg.width_log2 < level_cfg.height_log2) ?
			level_cfg.width_log2 : level_cfg.height_log2;
		tile_mask = ~({COORD_W{1'b1}} << side_log2);
		x_in_tile = texel.texel_x & tile_mask;
		y_in_tile = texel.texel_y & tile_mask;

		// y on even bits, x on odd bits
		for (int i = 0; i < COORD_W; i++) begin
			interleaved[2*i]   = y_in_tile[i];
			interleaved[2*i+1] = x_in_tile[i];
		end

		// only one of the two terms is nonzero for an in-range texel
		tile_num    = TILE_W'(texel.texel_x >> side_log2) + TILE_W'(texel.texel_y >> side_log2);
		tile_shift  = {side_log2, 1'b0};
		tile_base   = INDEX_W'({{(INDEX_W-TILE_W){1'b0}}, tile_num} << tile_shift);
		texel_index = interleaved + tile_base;

		outside = (|(texel.texel_x >> level_cfg.width_log2)) ||
			(|(texel.texel_y >> level_cfg.height_log2));

		result = '0;
		case (level_cfg.pixel_format)
			FMT_8BPP: begin
				offset             = {1'b0, texel_index};
				result.write_data  = {8'd0, texel.texel_value[7:0]};
				result.access_size = SIZE_BYTE;
			end
			FMT_4BPP: begin
				offset             = {2'b00, texel_index[INDEX_W-1:1]};
				result.write_data  = {12'd0, texel.texel_value[3:0]};
				result.access_size = SIZE_NIBBLE;
				result.high_nibble = texel_index[0];
			end
			default: begin
				// 16bpp, also the unused format code
				offset             = {texel_index, 1'b0};
				result.write_data  = texel.texel_value;
				result.access_size = SIZE_HALF;
			end
		endcase
		result.byte_address = {1'b0, level_cfg.base_address} +
			{{(ADDR_W-OFFSET_W){1'b0}}, offset};
		result.in_range = 1'b1;

		if (outside) begin
			result = '0;
		end
	end

endmodule

`default_nettype wire
